// File: hdl/uet_pkg.sv
package uet_pkg;

  // table sizing
  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 512;
  localparam int ADDR_W       = $clog2(MAX_EDGES);
  localparam int CNT_W        = $clog2(MAX_EDGES + 1);
  localparam int VTX_W        = 5;
  localparam int VCNT_W       = 6;
  localparam int ENTRY_W      = 2 * VTX_W;

  // capacity after reset: vertex_count = 32
  localparam int VCNT_RESET   = 32;
  localparam int CAP_RAW      = (VCNT_RESET * (VCNT_RESET - 1)) / 2;
  localparam int CAP_RESET    = (CAP_RAW > MAX_EDGES) ? MAX_EDGES : CAP_RAW;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic             found;
    logic             status;
    logic [CNT_W-1:0] edge_total;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic update;
    logic rd_last;
    logic wr_last;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic is_remove;
  } sts_t;

endpackage

// File: hdl/uet_ctrl.sv
module uet_ctrl (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  uet_pkg::sts_t sts,
  output uet_pkg::cmd_t cmd
);
  import uet_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_RDLAST = 6'b001000,
    ST_WRLAST = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.is_remove && sts.hit) state_nxt = ST_RDLAST;
        else state_nxt = ST_FINISH;
      end
      ST_RDLAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = ST_WRLAST;
      end
      ST_WRLAST: begin
        cmd.wr_last = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/uet_dpath.sv
module uet_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  uet_pkg::req_t              in_data,
  output uet_pkg::rsp_t              out_data,
  input  logic                       cfg_we,
  input  logic [uet_pkg::VCNT_W-1:0] cfg_data,
  input  uet_pkg::cmd_t              cmd,
  output uet_pkg::sts_t              sts
);
  import uet_pkg::*;

  logic [ENTRY_W-1:0] edge_mem [MAX_EDGES];

  req_t               req_r;
  rsp_t               out_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cap_r;
  logic [CNT_W-1:0]   scan_idx_r;
  logic [ADDR_W-1:0]  cmp_idx_r;
  logic               cmp_vld_r;
  logic               hit_r;
  logic [ADDR_W-1:0]  hit_idx_r;
  logic               status_r;
  logic [ENTRY_W-1:0] rd_data_r;

  logic               issue;
  logic               match;
  logic               full;
  logic               is_insert;
  logic [CNT_W-1:0]   cnt_m1;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_wa, mem_ra;
  logic [ENTRY_W-1:0] mem_wd;
  logic [VTX_W-1:0]   ent_p, ent_q;
  logic [VCNT_W-1:0]  vn_m1;
  logic [2*VCNT_W-1:0] prod;
  logic [2*VCNT_W-1:0] half;

  assign is_insert = (req_r.req_type == REQ_INSERT);
  assign full      = (count_r >= cap_r);
  assign cnt_m1    = count_r - CNT_W'(1);

  // compare stage on registered read data
  assign ent_p = rd_data_r[VTX_W-1:0];
  assign ent_q = rd_data_r[ENTRY_W-1:VTX_W];
  assign match = cmp_vld_r &&
                 (((ent_p == req_r.vertex_a) && (ent_q == req_r.vertex_b)) ||
                  ((ent_p == req_r.vertex_b) && (ent_q == req_r.vertex_a)));

  // one read per cycle while entries remain and nothing matched yet
  assign issue = cmd.scan && !hit_r && !match && (scan_idx_r < count_r);

  assign sts.scan_done = hit_r || ((scan_idx_r >= count_r) && !cmp_vld_r);
  assign sts.hit       = hit_r;
  assign sts.is_remove = (req_r.req_type == REQ_REMOVE);

  // memory port selection
  always_comb begin
    mem_re = issue || cmd.rd_last;
    mem_ra = cmd.rd_last ? cnt_m1[ADDR_W-1:0] : scan_idx_r[ADDR_W-1:0];
    mem_we = 1'b0;
    mem_wa = count_r[ADDR_W-1:0];
    mem_wd = {req_r.vertex_b, req_r.vertex_a};
    if (cmd.update && is_insert && !full && !hit_r) begin
      mem_we = 1'b1;
    end else if (cmd.wr_last) begin
      mem_we = 1'b1;
      mem_wa = hit_idx_r;
      mem_wd = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) edge_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= edge_mem[mem_ra];
  end

  // edge count
  always_comb begin
    count_nxt = count_r;
    if (cmd.update && is_insert && !full && !hit_r) count_nxt = count_r + CNT_W'(1);
    else if (cmd.wr_last) count_nxt = cnt_m1;
  end

  // capacity n*(n-1)/2, capped
  assign vn_m1 = cfg_data - VCNT_W'(1);
  assign prod  = (2*VCNT_W)'(cfg_data) * (2*VCNT_W)'(vn_m1);
  assign half  = prod >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cap_r     <= CNT_W'(CAP_RESET);
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        if (half > (2*VCNT_W)'(MAX_EDGES)) cap_r <= CNT_W'(MAX_EDGES);
        else cap_r <= CNT_W'(half);
      end
      if (cmd.start) begin
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
      end else begin
        cmp_vld_r <= issue;
        if (match && !hit_r) hit_r <= 1'b1;
      end
    end
  end

  // request, scan pointer and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r      <= in_data;
      scan_idx_r <= '0;
    end else if (issue) begin
      scan_idx_r <= scan_idx_r + CNT_W'(1);
    end
    if (issue) cmp_idx_r <= scan_idx_r[ADDR_W-1:0];
    if (match && !hit_r) hit_idx_r <= cmp_idx_r;
    if (cmd.update) status_r <= is_insert && full;
    if (cmd.load_out) begin
      out_r.found      <= hit_r;
      out_r.status     <= status_r;
      out_r.edge_total <= count_r;
    end
  end

  assign out_data = out_r;

endmodule

// File: hdl/undirected_edge_table_unit.sv
// Flow: a request is taken only in idle, then the scan walks the edge memory
//   through its single read port one entry per cycle; a hit ends the scan early,
//   and a remove that hits then moves the last entry into the freed slot.
// A new request is taken only after the result is loaded into the output
//   register, which waits while an earlier result is still held by the receiver.
// Reset (rst_n low, synchronous): edge count 0, capacity from 32 vertices,
//   controller idle, no result pending; memory contents are not cleared.
module undirected_edge_table_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  uet_pkg::req_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output uet_pkg::rsp_t              out_data,
  input  logic                       cfg_we,
  input  logic [uet_pkg::VCNT_W-1:0] cfg_data
);
  import uet_pkg::*;

  cmd_t cmd;
  sts_t sts;

  uet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  uet_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

  // busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in progress");

  // a result never appears the cycle after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid || $past(out_valid))
    else $error("result raised too early after request");

  // stored edge count stays within the table
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.edge_total <= CNT_W'(MAX_EDGES))
    else $error("edge total beyond table size");

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uet_pkg::*;

  // request code 3 is not decoded by the block and behaves as a query
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         N_PAIRS    = (MAX_VERTICES * (MAX_VERTICES + 1)) / 2;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  req_t               in_data;
  logic               out_valid;
  logic               out_ready;
  rsp_t               out_data;
  logic               cfg_we;
  logic [VCNT_W-1:0]  cfg_data;

  // one directed stimulus row: a register write or a request
  typedef struct {
    bit                is_cfg;
    logic [VCNT_W-1:0] cfg_val;
    req_t              req;
    bit                pinned;
    rsp_t              rsp;
  } stim_row_t;

  // table model
  logic [ENTRY_W-1:0] edge_mem_model [MAX_EDGES];
  int                 edge_cnt_model;
  int                 vcnt_model;

  rsp_t      pending_rsp_q [$];
  stim_row_t directed_q [$];
  int        err_cnt;
  int        idle_pct;
  bit        pin_en;
  rsp_t      pin_rsp;

  undirected_edge_table_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scan the model table for the pair, then apply the request
  function automatic rsp_t table_step(input req_t r);
    int   cap;
    int   hit;
    bit   present;
    rsp_t o;
    cap     = (vcnt_model == 0) ? 0 : (vcnt_model * (vcnt_model - 1)) / 2;
    cap     = (cap > MAX_EDGES) ? MAX_EDGES : cap;
    present = 1'b0;
    hit     = 0;
    for (int i = 0; i < edge_cnt_model && !present; i++) begin
      if (edge_mem_model[i] == {r.vertex_b, r.vertex_a} ||
          edge_mem_model[i] == {r.vertex_a, r.vertex_b}) begin
        present = 1'b1;
        hit     = i;
      end
    end
    o.found  = present;
    o.status = 1'b0;
    if (r.req_type == REQ_INSERT) begin
      if (edge_cnt_model >= cap) begin
        o.status = 1'b1;
      end else if (!present) begin
        edge_mem_model[edge_cnt_model] = {r.vertex_b, r.vertex_a};
        edge_cnt_model++;
      end
    end else if (r.req_type == REQ_REMOVE && present) begin
      edge_cnt_model--;
      edge_mem_model[hit] = edge_mem_model[edge_cnt_model];
    end
    o.edge_total = CNT_W'(edge_cnt_model);
    return o;
  endfunction

  // predict on accepted requests, check accepted responses
  always @(posedge clk) begin : monitor
    rsp_t want;
    rsp_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with none pending: found %0d status %0d edge_total %0d",
                 out_data.found, out_data.status, out_data.edge_total);
          err_cnt++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_data.found);
            err_cnt++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            err_cnt++;
          end
          if (out_data.edge_total !== want.edge_total) begin
            $error("edge_total: expected %0d, actual %0d",
                   want.edge_total, out_data.edge_total);
            err_cnt++;
          end
        end
      end
      if (cfg_we) begin
        vcnt_model = int'(cfg_data);
      end
      if (in_valid && in_ready) begin
        pred = table_step(in_data);
        pending_rsp_q.push_back(pin_en ? pin_rsp : pred);
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  function automatic req_t mk_req(logic [1:0] op, int a, int b);
    req_t r;
    r.req_type = op;
    r.vertex_a = VTX_W'(a);
    r.vertex_b = VTX_W'(b);
    return r;
  endfunction

  function automatic stim_row_t req_row(logic [1:0] op, int a, int b, bit pin,
                                        bit f, bit s, int tot);
    stim_row_t row;
    row.is_cfg         = 1'b0;
    row.cfg_val        = '0;
    row.req            = mk_req(op, a, b);
    row.pinned         = pin;
    row.rsp.found      = f;
    row.rsp.status     = s;
    row.rsp.edge_total = CNT_W'(tot);
    return row;
  endfunction

  function automatic stim_row_t cfg_row(int n);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = VCNT_W'(n);
    row.req     = '0;
    row.pinned  = 1'b0;
    row.rsp     = '0;
    return row;
  endfunction

  function automatic int pick_vertex(int hi, int noise);
    return ($urandom_range(0, 99) < noise) ? $urandom_range(0, 31) : $urandom_range(0, hi);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(req_t r, bit pin, rsp_t pv);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    pin_en   = pin;
    pin_rsp  = pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every response is back
  task automatic drain;
    in_valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_vcount(int n);
    drain();
    cfg_we   = 1'b1;
    cfg_data = VCNT_W'(n);
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic run_random(int n_items, int vhi, int noise);
    int         roll;
    logic [1:0] op;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      op   = (roll < 45) ? REQ_INSERT : (roll < 70) ? REQ_REMOVE :
             (roll < 95) ? REQ_QUERY : REQ_UNUSED;
      send_req(mk_req(op, pick_vertex(vhi, noise), pick_vertex(vhi, noise)), 1'b0, '0);
    end
  endtask

  // insert every unordered pair once, in shuffled order, so that the table overflows
  task automatic fill_table;
    int pa [N_PAIRS];
    int pb [N_PAIRS];
    int k;
    int j;
    int t;
    k = 0;
    for (int a = 0; a < MAX_VERTICES; a++) begin
      for (int b = a; b < MAX_VERTICES; b++) begin
        pa[k] = a;
        pb[k] = b;
        k++;
      end
    end
    for (int i = N_PAIRS - 1; i > 0; i--) begin
      j     = $urandom_range(0, i);
      t     = pa[i];
      pa[i] = pa[j];
      pa[j] = t;
      t     = pb[i];
      pb[i] = pb[j];
      pb[j] = t;
    end
    for (int i = 0; i < N_PAIRS; i++) begin
      if ($urandom_range(0, 1) == 1)
        send_req(mk_req(REQ_INSERT, pa[i], pb[i]), 1'b0, '0);
      else
        send_req(mk_req(REQ_INSERT, pb[i], pa[i]), 1'b0, '0);
    end
  endtask

  // run limit
  initial begin
    #30ms;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    pin_en         = 1'b0;
    pin_rsp        = '0;
    err_cnt        = 0;
    idle_pct       = 36;
    edge_cnt_model = 0;
    vcnt_model     = VCNT_RESET;

    // directed: reset capacity of 32 vertices, then a shrunk capacity
    directed_q.push_back(req_row(REQ_QUERY,   3,  5, 1, 0, 0, 0));
    directed_q.push_back(req_row(REQ_REMOVE,  3,  5, 1, 0, 0, 0));
    directed_q.push_back(req_row(REQ_INSERT,  3,  5, 1, 0, 0, 1));
    directed_q.push_back(req_row(REQ_INSERT,  5,  3, 1, 1, 0, 1));
    directed_q.push_back(req_row(REQ_QUERY,   5,  3, 1, 1, 0, 1));
    directed_q.push_back(req_row(REQ_UNUSED,  3,  5, 1, 1, 0, 1));
    directed_q.push_back(req_row(REQ_INSERT,  0,  0, 1, 0, 0, 2));
    directed_q.push_back(req_row(REQ_INSERT, 31, 31, 1, 0, 0, 3));
    directed_q.push_back(req_row(REQ_INSERT,  0, 31, 1, 0, 0, 4));
    directed_q.push_back(req_row(REQ_INSERT, 31,  0, 1, 1, 0, 4));
    directed_q.push_back(req_row(REQ_QUERY,  31, 31, 1, 1, 0, 4));
    directed_q.push_back(req_row(REQ_REMOVE, 31,  0, 1, 1, 0, 3));
    directed_q.push_back(req_row(REQ_REMOVE,  0, 31, 1, 0, 0, 3));
    // first entry removed: last entry moves into its slot
    directed_q.push_back(req_row(REQ_REMOVE,  3,  5, 0, 0, 0, 0));
    directed_q.push_back(req_row(REQ_QUERY,  31, 31, 0, 0, 0, 0));
    directed_q.push_back(req_row(REQ_QUERY,   0,  0, 0, 0, 0, 0));
    directed_q.push_back(req_row(REQ_INSERT, 21, 10, 1, 0, 0, 3));
    directed_q.push_back(req_row(REQ_INSERT, 10, 21, 1, 1, 0, 3));
    directed_q.push_back(req_row(REQ_QUERY,  10, 21, 0, 0, 0, 0));
    directed_q.push_back(req_row(REQ_UNUSED,  1,  2, 1, 0, 0, 3));
    // capacity 1 with three stored: inserts rejected, found still reported
    directed_q.push_back(cfg_row(2));
    directed_q.push_back(req_row(REQ_INSERT,  1,  2, 1, 0, 1, 3));
    directed_q.push_back(req_row(REQ_INSERT,  0,  0, 1, 1, 1, 3));
    directed_q.push_back(req_row(REQ_REMOVE,  0,  0, 1, 1, 0, 2));
    directed_q.push_back(req_row(REQ_QUERY,  31, 31, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_q[i]) begin
      if (directed_q[i].is_cfg)
        write_vcount(int'(directed_q[i].cfg_val));
      else
        send_req(directed_q[i].req, directed_q[i].pinned, directed_q[i].rsp);
    end

    // small tables that fill and overflow often
    write_vcount(4);
    run_random(150, 4, 5);
    // zero capacity with edges still stored
    write_vcount(0);
    run_random(30, 4, 5);
    // largest setting: capacity capped, fill to the cap and beyond
    write_vcount(63);
    fill_table();
    // capacity far below a full table, no idling on either side
    write_vcount(5);
    idle_pct = 0;
    run_random(200, 31, 0);
    idle_pct = 36;
    write_vcount(1);
    run_random(40, 31, 0);
    write_vcount(32);
    run_random(200, 31, 0);

    drain();
    repeat (600) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
